/* rtl/core/etfd_pkg.sv */
// Shared types and constants for the escaped telemetry frame deframer.
// No dependencies; every other file in rtl/core except etfd_ram imports this package.
package etfd_pkg;

   // Configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH_MODE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_LIMIT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FLAG_VALUE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE_VALUE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE_XOR   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FIXED_LENGTH = 3'd5;

   localparam int CSR_DATA_W = 16;
   localparam int LEN_W      = 7;

   // Reset values of the configuration registers
   localparam logic        RST_LENGTH_MODE  = 1'b1;
   localparam logic [15:0] RST_GAP_LIMIT    = 16'd20000;
   localparam logic [7:0]  RST_FLAG_VALUE   = 8'd126;
   localparam logic [7:0]  RST_ESCAPE_VALUE = 8'd125;
   localparam logic [7:0]  RST_ESCAPE_XOR   = 8'd32;
   localparam logic [6:0]  RST_FIXED_LENGTH = 7'd9;

   typedef struct packed {
      logic             length_mode;
      logic [15:0]      gap_limit;
      logic [7:0]       flag_value;
      logic [7:0]       escape_value;
      logic [7:0]       escape_xor;
      logic [LEN_W-1:0] fixed_length;
   } cfg_type;

   // Deframer phase
   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_START = 2'd1,
      PH_FRAME = 2'd2,
      PH_ESC   = 2'd3
   } phase_type;

   // Output sequencer state
   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_SEND = 1'b1
   } back_state_type;

   // Completed frame: which buffer half and how many bytes
   typedef struct packed {
      logic             bank;
      logic [LEN_W-1:0] count;
   } desc_type;

   // Buffer half handed back by the output side
   typedef struct packed {
      logic valid;
      logic bank;
   } release_type;

endpackage

/* rtl/core/escaped_telemetry_frame_deframer.sv */
// Top level of the escaped telemetry frame deframer: configuration registers
// and the front, queue, frame RAM and back instances. Depends on etfd_pkg.
//
// The block takes one received line byte per word, deframes flag-delimited,
// escape-stuffed frames and sends each completed frame as one output word per
// byte. The front end takes a word every cycle while req_ready is high. Frames
// are collected into one half of a two-frame RAM; when a frame completes the
// front switches halves, and it holds req_ready low only while the half it
// would fill next has not yet been released by the back end. The back end
// sends one word per cycle while rsp_ready is high, after first fetching the
// first byte of a frame from the RAM. No clearing pass is needed after reset.
module escaped_telemetry_frame_deframer #(
   parameter int MAX_FRAME = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic [15:0] req_arrival_tick,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_frame_byte,
   output logic [5:0]  rsp_byte_position,
   output logic [6:0]  rsp_frame_bytes,
   output logic        rsp_last_of_frame,
   input  logic        csr_write_enable,
   input  logic [etfd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [etfd_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import etfd_pkg::*;

   localparam int RAM_DEPTH  = 2 * (2 ** $clog2(MAX_FRAME));
   localparam int RAM_ADDR_W = $clog2(RAM_DEPTH);

   cfg_type cfg_ff, cfg_in;

   logic                  wr_en;
   logic [RAM_ADDR_W-1:0] wr_addr;
   logic [7:0]            wr_data;
   logic [RAM_ADDR_W-1:0] rd_addr;
   logic [7:0]            rd_data;
   logic                  push_valid;
   desc_type              push_desc;
   logic                  pop;
   logic                  desc_valid;
   desc_type              head;
   release_type           release_bank;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_LENGTH_MODE:  cfg_in.length_mode  = csr_write_data[0];
            CSR_GAP_LIMIT:    cfg_in.gap_limit    = csr_write_data[15:0];
            CSR_FLAG_VALUE:   cfg_in.flag_value   = csr_write_data[7:0];
            CSR_ESCAPE_VALUE: cfg_in.escape_value = csr_write_data[7:0];
            CSR_ESCAPE_XOR:   cfg_in.escape_xor   = csr_write_data[7:0];
            CSR_FIXED_LENGTH: cfg_in.fixed_length = csr_write_data[6:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{length_mode:  RST_LENGTH_MODE,
                     gap_limit:    RST_GAP_LIMIT,
                     flag_value:   RST_FLAG_VALUE,
                     escape_value: RST_ESCAPE_VALUE,
                     escape_xor:   RST_ESCAPE_XOR,
                     fixed_length: RST_FIXED_LENGTH};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   etfd_front #(
      .MAX_FRAME (MAX_FRAME)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .rx_byte      (req_rx_byte),
      .arrival_tick (req_arrival_tick),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .push_valid   (push_valid),
      .push_desc    (push_desc),
      .release_bank (release_bank)
   );

   etfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_desc  (push_desc),
      .pop        (pop),
      .not_empty  (desc_valid),
      .head       (head)
   );

   etfd_ram #(
      .WIDTH (8),
      .DEPTH (RAM_DEPTH)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   etfd_back #(
      .MAX_FRAME (MAX_FRAME)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .desc_valid        (desc_valid),
      .desc              (head),
      .pop               (pop),
      .rd_addr           (rd_addr),
      .rd_data           (rd_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_byte    (rsp_frame_byte),
      .rsp_byte_position (rsp_byte_position),
      .rsp_frame_bytes   (rsp_frame_bytes),
      .rsp_last_of_frame (rsp_last_of_frame),
      .release_bank      (release_bank)
   );

endmodule

/* rtl/core/etfd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module etfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/etfd_front.sv */
// Front end: deframing state machine, gap timeout and frame buffer writes.
// Depends on etfd_pkg; writes the frame RAM and pushes completed frames.
module etfd_front #(
   parameter int MAX_FRAME = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  etfd_pkg::cfg_type      cfg,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             rx_byte,
   input  logic [15:0]            arrival_tick,
   output logic                   wr_en,
   output logic [$clog2(MAX_FRAME):0] wr_addr,
   output logic [7:0]             wr_data,
   output logic                   push_valid,
   output etfd_pkg::desc_type     push_desc,
   input  etfd_pkg::release_type  release_bank
);
   import etfd_pkg::*;

   localparam int IDX_W = $clog2(MAX_FRAME);
   localparam int CNT_W = $clog2(MAX_FRAME + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME);
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_FRAME);

   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [15:0]      prev_tick_ff, prev_tick_in;
   logic             bank_ff, bank_in;
   logic [1:0]       busy_ff, busy_in;

   logic             accept;
   logic             is_flag;
   logic [15:0]      diff;
   logic             put;
   logic             emit;
   logic [LEN_W-1:0] eff_len;
   logic [CNT_W-1:0] emit_count;

   assign req_ready = !busy_ff[bank_ff];
   assign accept    = req_valid && req_ready;
   assign is_flag   = (rx_byte == cfg.flag_value);
   assign diff      = arrival_tick - prev_tick_ff;
   assign eff_len   = (cfg.fixed_length > LEN_MAX) ? LEN_MAX : cfg.fixed_length;
   assign wr_addr   = {bank_ff, count_ff[IDX_W-1:0]};

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      prev_tick_in = prev_tick_ff;
      bank_in      = bank_ff;
      busy_in      = busy_ff;
      put          = 1'b0;
      emit         = 1'b0;
      wr_en        = 1'b0;
      wr_data      = rx_byte;
      emit_count   = '0;
      push_valid   = 1'b0;
      push_desc    = '{bank: bank_ff, count: '0};

      if (release_bank.valid) begin
         busy_in[release_bank.bank] = 1'b0;
      end

      if (accept) begin
         if (cfg.length_mode) begin
            prev_tick_in = arrival_tick;
         end
         if (cfg.length_mode && (diff > cfg.gap_limit) && !is_flag) begin
            phase_in = PH_IDLE;
            count_in = '0;
         end else begin
            unique case (phase_ff)
               PH_IDLE: begin
                  if (is_flag) begin
                     phase_in = PH_START;
                     count_in = '0;
                  end
               end
               PH_START: begin
                  if (is_flag) begin
                     if (cfg.length_mode) begin
                        phase_in = PH_FRAME;
                        count_in = '0;
                     end
                  end else begin
                     put      = 1'b1;
                     phase_in = PH_FRAME;
                  end
               end
               PH_FRAME: begin
                  if (rx_byte == cfg.escape_value) begin
                     phase_in = PH_ESC;
                  end else if (is_flag) begin
                     if (cfg.length_mode) begin
                        count_in = '0;
                     end else begin
                        emit = 1'b1;
                     end
                  end else begin
                     put = 1'b1;
                  end
               end
               PH_ESC: begin
                  put      = 1'b1;
                  wr_data  = rx_byte ^ cfg.escape_xor;
                  phase_in = PH_FRAME;
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase

            // bytes past the buffer end are dropped, count saturates
            if (put && (count_ff < CNT_MAX)) begin
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end

            if (cfg.length_mode && (phase_in == PH_FRAME) &&
                (LEN_W'(count_in) >= eff_len)) begin
               emit = 1'b1;
            end

            if (emit) begin
               emit_count = count_in;
               phase_in   = PH_IDLE;
               count_in   = '0;
               // an empty frame produces no output words
               if (emit_count != '0) begin
                  push_valid       = 1'b1;
                  push_desc.count  = LEN_W'(emit_count);
                  busy_in[bank_ff] = 1'b1;
                  bank_in          = !bank_ff;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         count_ff     <= '0;
         prev_tick_ff <= '0;
         bank_ff      <= 1'b0;
         busy_ff      <= '0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         prev_tick_ff <= prev_tick_in;
         bank_ff      <= bank_in;
         busy_ff      <= busy_in;
      end
   end

endmodule

/* rtl/core/etfd_queue.sv */
// Two-entry queue of completed frame descriptors between front and back.
// Depends on etfd_pkg. Never overflows: each entry owns one buffer half.
module etfd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  etfd_pkg::desc_type push_desc,
   input  logic               pop,
   output logic               not_empty,
   output etfd_pkg::desc_type head
);
   import etfd_pkg::*;

   desc_type   entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_pop;

   assign not_empty = (fill_ff != 2'd0);
   assign head      = entries_ff[rd_ptr_ff];
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push_valid) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (do_pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push_valid && !do_pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (!push_valid && do_pop) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

/* rtl/core/etfd_back.sv */
// Back end: reads a completed frame from the RAM and sends one word per byte.
// Depends on etfd_pkg; pops the descriptor queue and releases buffer halves.
module etfd_back #(
   parameter int MAX_FRAME = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       desc_valid,
   input  etfd_pkg::desc_type         desc,
   output logic                       pop,
   output logic [$clog2(MAX_FRAME):0] rd_addr,
   input  logic [7:0]                 rd_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [7:0]                 rsp_frame_byte,
   output logic [5:0]                 rsp_byte_position,
   output logic [6:0]                 rsp_frame_bytes,
   output logic                       rsp_last_of_frame,
   output etfd_pkg::release_type      release_bank
);
   import etfd_pkg::*;

   localparam int IDX_W = $clog2(MAX_FRAME);

   back_state_type   state_ff, state_in;
   logic             bank_ff, bank_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [LEN_W-1:0] count_ff, count_in;
   logic             last;

   assign last = ((LEN_W'(idx_ff) + LEN_W'(1)) == count_ff);

   always_comb begin
      state_in     = state_ff;
      bank_in      = bank_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      pop          = 1'b0;
      release_bank = '{valid: 1'b0, bank: bank_ff};
      unique case (state_ff)
         BK_IDLE: begin
            if (desc_valid) begin
               pop      = 1'b1;
               bank_in  = desc.bank;
               count_in = desc.count;
               idx_in   = '0;
               state_in = BK_SEND;
            end
         end
         BK_SEND: begin
            if (rsp_ready) begin
               if (last) begin
                  release_bank.valid = 1'b1;
                  state_in           = BK_IDLE;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // read address follows the next index so the registered read data lines up with idx_ff
   assign rd_addr = {bank_in, idx_in};

   assign rsp_valid         = (state_ff == BK_SEND);
   assign rsp_frame_byte    = rd_data;
   assign rsp_byte_position = 6'(idx_ff);
   assign rsp_frame_bytes   = count_ff;
   assign rsp_last_of_frame = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      bank_ff  <= bank_in;
      idx_ff   <= idx_in;
      count_ff <= count_in;
   end

endmodule
